// ===== design/bhmf_pkg.sv =====
// Shared types, constants and the gray-level function for the black hole median fill.
// No dependencies; every other file in the design takes names from here.
`timescale 1ns / 1ps

package bhmf_pkg;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

    // Gray weights, Q14, with rounding
    localparam logic [21:0] GRAY_COEF_B = 22'd1868;
    localparam logic [21:0] GRAY_COEF_G = 22'd9617;
    localparam logic [21:0] GRAY_COEF_R = 22'd4899;
    localparam logic [21:0] GRAY_ROUND  = 22'd8192;

    localparam int QUEUE_DEPTH = 4;

    typedef logic [23:0] pixel_t;   // blue [7:0], green [15:8], red [23:16]

    // One classified pixel on its way from the front to the back end
    typedef struct packed {
        pixel_t     cur;
        pixel_t     ul;
        pixel_t     up;
        pixel_t     lf;
        logic [7:0] g_ul;
        logic [7:0] g_up;
        logic [7:0] g_lf;
        logic       fill;   // interior pixel with zero gray
        logic       last;   // last pixel of the frame
    } item_t;

    function automatic logic [7:0] gray_of(input pixel_t px);
        logic [21:0] sum;
        sum = GRAY_COEF_B * {14'd0, px[7:0]}
            + GRAY_COEF_G * {14'd0, px[15:8]}
            + GRAY_COEF_R * {14'd0, px[23:16]}
            + GRAY_ROUND;
        return sum[21:14];
    endfunction

endpackage

// ===== design/black_hole_median_fill.sv =====
// Top level of the black hole median fill: configuration registers and stream ports.
// Uses bhmf_pkg, bhmf_front, bhmf_queue and bhmf_back.
// Path: a pixel passes the stage-two registers, the queue and the output register.
// Throughput: one pixel per clock unless stalled, set by the single-port line store (one read, one write).
// Either side may stall on its own; a four-entry queue sits between front and back.
// Reset (aresetn low, synchronous): counters, neighbours and queue cleared, width 640,
// height 480; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module black_hole_median_fill #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // blue_in [7:0], green_in [15:8], red_in [23:16]
    // pixel output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // blue_out [7:0], green_out [15:8], red_out [23:16]
    output logic        m_tuser,    // was_filled
    output logic        m_tlast     // frame_end
);

    // Configuration; the user must write it only while the stream is idle (not enforced)
    logic [11:0] image_width_reg;
    logic [15:0] image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= bhmf_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= bhmf_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bhmf_pkg::REG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_wdata[11:0];
                end
                bhmf_pkg::REG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    logic            push_valid, push_ready, pop_valid, pop_ready;
    bhmf_pkg::item_t push_item, pop_item;

    // Front: tracks the raster position, reads the previous row from the line store
    // and marks interior black pixels for filling.
    bhmf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_pixel     (s_tdata),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    // Queue: lets the front keep taking transfers while the output is briefly held.
    bhmf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: picks the median-ranked non-black neighbour and registers the result.
    bhmf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (m_tdata),
        .out_filled (m_tuser),
        .out_last   (m_tlast)
    );

    a_cfg_width: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == bhmf_pkg::REG_IMAGE_WIDTH
        |=> image_width_reg == $past(cfg_wdata[11:0]))
        else $error("width register not updated by write");

    a_cfg_height_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_wr_en |=> $stable(image_height_reg) && $stable(image_width_reg))
        else $error("configuration changed without a write");

endmodule

// ===== design/bhmf_front.sv =====
// Front end: raster position, line store, neighbour capture and classification.
// Uses bhmf_pkg; feeds bhmf_queue.
`timescale 1ns / 1ps

module bhmf_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [11:0]         image_width,
    input  logic [15:0]         image_height,
    input  logic                in_valid,
    output logic                in_ready,
    input  bhmf_pkg::pixel_t    in_pixel,
    output logic                push_valid,
    input  logic                push_ready,
    output bhmf_pkg::item_t     push_item
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

    logic [CW-1:0]    col_reg, col_next;
    logic [15:0]      row_reg, row_next;
    bhmf_pkg::pixel_t line_mem [MAX_WIDTH];
    bhmf_pkg::pixel_t rd_reg;       // upper pixel of the last accepted item
    bhmf_pkg::pixel_t lf_reg;       // last accepted pixel

    logic             s2_valid_reg;
    bhmf_pkg::pixel_t s2_cur_reg, s2_ul_reg, s2_lf_reg;
    logic             s2_fill_reg, s2_last_reg;

    logic [WW-1:0] w_ext, w_eff, col_p1;
    logic [16:0]   h_eff, row_p1;
    logic          last_col, last_row, interior, accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !s2_valid_reg || push_ready;

    always_comb begin
        w_ext = WW'(image_width);
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff    = (image_height == 16'd0) ? 17'd1 : {1'b0, image_height};
        col_p1   = WW'(col_reg) + WW'(1);
        row_p1   = {1'b0, row_reg} + 17'd1;
        last_col = col_p1 >= w_eff;
        last_row = row_p1 >= h_eff;
        interior = (row_reg != 16'd0) && (row_p1 < h_eff)
                && (col_reg != '0) && (col_p1 < w_eff);
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? 16'd0 : row_p1[15:0];
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= 16'd0;
            rd_reg       <= '0;
            lf_reg       <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                rd_reg  <= line_mem[col_reg];
                lf_reg  <= in_pixel;
            end
            if (accept) begin
                s2_valid_reg <= 1'b1;
            end else if (push_ready) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // Line store write; the read above returns the previous row's value
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_mem[col_reg] <= in_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_cur_reg  <= in_pixel;
            s2_ul_reg   <= rd_reg;
            s2_lf_reg   <= lf_reg;
            s2_fill_reg <= interior && (bhmf_pkg::gray_of(in_pixel) == 8'd0);
            s2_last_reg <= last_col && last_row;
        end
    end

    always_comb begin
        push_valid     = s2_valid_reg;
        push_item.cur  = s2_cur_reg;
        push_item.ul   = s2_ul_reg;
        push_item.up   = rd_reg;
        push_item.lf   = s2_lf_reg;
        push_item.g_ul = bhmf_pkg::gray_of(s2_ul_reg);
        push_item.g_up = bhmf_pkg::gray_of(rd_reg);
        push_item.g_lf = bhmf_pkg::gray_of(s2_lf_reg);
        push_item.fill = s2_fill_reg;
        push_item.last = s2_last_reg;
    end

    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_col |=> col_reg == '0)
        else $error("column counter did not wrap at end of row");

    a_hold_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !push_ready |=> s2_valid_reg && $stable(s2_cur_reg))
        else $error("stalled stage two item was lost");

endmodule

// ===== design/bhmf_queue.sv =====
// Short register queue decoupling the front end from the fill back end.
// Uses bhmf_pkg for the item type and depth.
`timescale 1ns / 1ps

module bhmf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  bhmf_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output bhmf_pkg::item_t pop_item
);

    localparam int PW = $clog2(bhmf_pkg::QUEUE_DEPTH);

    bhmf_pkg::item_t slot_reg [bhmf_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg, count_next;
    logic            push, pop;

    assign push_ready = count_reg != (PW+1)'(bhmf_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(bhmf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ptr_reg - rd_ptr_reg == count_reg[PW-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ===== design/bhmf_back.sv =====
// Back end: stable-rank median pick among nonzero-gray neighbours, output register.
// Uses bhmf_pkg; takes items from bhmf_queue.
`timescale 1ns / 1ps

module bhmf_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  bhmf_pkg::item_t pop_item,
    output logic            out_valid,
    input  logic            out_ready,
    output bhmf_pkg::pixel_t out_pixel,
    output logic            out_filled,
    output logic            out_last
);

    logic             valid_reg;
    bhmf_pkg::pixel_t pixel_reg;
    logic             filled_reg, last_reg;

    bhmf_pkg::pixel_t nb   [3];
    logic [7:0]       gr   [3];
    logic [2:0]       cand;
    logic [1:0]       rank [3];
    logic [1:0]       n_cand, target;
    bhmf_pkg::pixel_t pick;
    logic             hit, pop;

    assign pop_ready = !valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        nb[0] = pop_item.ul;   gr[0] = pop_item.g_ul;
        nb[1] = pop_item.up;   gr[1] = pop_item.g_up;
        nb[2] = pop_item.lf;   gr[2] = pop_item.g_lf;
        for (int i = 0; i < 3; i++) begin
            cand[i] = gr[i] != 8'd0;
        end
        n_cand = 2'($countones(cand));
        target = n_cand >> 1;
        // position in the gray order, ties broken by scan order
        for (int i = 0; i < 3; i++) begin
            rank[i] = 2'd0;
            for (int j = 0; j < 3; j++) begin
                if (cand[j] && j != i
                    && ((gr[j] < gr[i]) || ((gr[j] == gr[i]) && (j < i)))) begin
                    rank[i] = rank[i] + 2'd1;
                end
            end
        end
        pick = pop_item.cur;
        hit  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (cand[i] && rank[i] == target) begin
                pick = nb[i];
                hit  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            pixel_reg  <= (pop_item.fill && hit) ? pick : pop_item.cur;
            filled_reg <= pop_item.fill && hit;
            last_reg   <= pop_item.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_pixel  = pixel_reg;
    assign out_filled = filled_reg;
    assign out_last   = last_reg;

    a_fill_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && filled_reg |-> bhmf_pkg::gray_of(pixel_reg) != 8'd0)
        else $error("filled pixel copied from a black neighbour");

    a_pass_through: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !pop_item.fill |=> pixel_reg == $past(pop_item.cur) && !filled_reg)
        else $error("unfilled pixel altered");

endmodule
